// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each use samples on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside of reset.
`define MKSS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("mkss: assertion failed");

// Check a property that also spans reset.
`define MKSS_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("mkss: reset assertion failed");

`endif

// ===== rtl/core/mkss_pkg.sv =====
package mkss_pkg;

   // MurmurHash2 mixing multiplier
   localparam logic [31:0] MIX_MULT = 32'h5bd1e995;

   localparam int HASH_W  = 32;
   localparam int NODE_W  = 7;
   localparam int INDEX_W = 6;

   // Node count clamp bounds
   localparam logic [NODE_W-1:0] NODE_MIN = 7'd1;
   localparam logic [NODE_W-1:0] NODE_MAX = 7'd64;

   // Request word as it arrives on the input channel
   typedef struct packed {
      logic [31:0] key_word;
      logic [2:0]  byte_count;
      logic        first_word;
      logic        last_word;
      logic [15:0] key_length;
   } mkss_req_type;

   // Result word
   typedef struct packed {
      logic [HASH_W-1:0]  hash_value;
      logic [INDEX_W-1:0] server_index;
   } mkss_rsp_type;

   // How a word enters the hash loop
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_TAIL,
      KIND_FULL
   } mkss_kind_type;

   // Classified word passed from front to back through the queue
   typedef struct packed {
      logic [31:0]   data;
      mkss_kind_type kind;
      logic          first;
      logic          last;
      logic [15:0]   length;
   } mkss_work_type;

endpackage

// ===== rtl/core/mkss_chan_if.sv =====
interface mkss_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/murmur2_key_shard_select.sv =====
// Channel   Dir  Word                                            Handshake
// req_chan  in   key_word, byte_count, first/last_word, length   valid/ready
// rsp_chan  out  hash_value, server_index                        valid/ready
// csr_chan  in   node_count (7 bits)                             valid/ready
//
// Each key word passes through the hash loop's single 32x32 multiplier;
// words ahead of it are k-mixed in a two-multiply front.
// After the last word of a key come two finalize steps and 32 steps
// of the bit-serial remainder unit, then the result is loaded.
// Synchronous reset clears the queue, the running hash and the result
// valid; node_count returns to 1. Input stalls only when the queue fills.
module murmur2_key_shard_select
   import mkss_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   mkss_chan_if.sink   req_chan,
   mkss_chan_if.source rsp_chan,
   mkss_chan_if.sink   csr_chan
);

   logic              push_valid;
   logic              push_ready;
   mkss_work_type     push_data;
   logic              pop_valid;
   logic              pop_ready;
   mkss_work_type     pop_data;
   logic [NODE_W-1:0] node_count_ff;
   mkss_req_type      req_word;
   mkss_rsp_type      rsp_word;
   logic              rsp_valid;

   // Node count register, always writable
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_MIN;
      end else if (csr_chan.valid) begin
         node_count_ff <= csr_chan.data[NODE_W-1:0];
      end
   end

   assign req_word = req_chan.data;

   mkss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_data    (req_word),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   mkss_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mkss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .node_count (node_count_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_data   (rsp_word)
   );

   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.data  = rsp_word;

endmodule

// ===== rtl/core/mkss_front.sv =====
module mkss_front
   import mkss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  mkss_req_type  in_data,
   output logic          push_valid,
   input  logic          push_ready,
   output mkss_work_type push_data
);

   logic          s1_valid_ff, s1_valid_in;
   logic [31:0]   s1_data_ff, s1_data_in;
   mkss_kind_type s1_kind_ff, s1_kind_in;
   logic          s1_first_ff;
   logic          s1_last_ff;
   logic [15:0]   s1_len_ff;
   logic          accept;
   logic [31:0]   masked_word;
   logic [31:0]   full_prod;
   logic [31:0]   k_shift;
   logic [31:0]   k_mix;

   // Take a word when the stage is empty or drains this cycle
   assign in_ready = !s1_valid_ff || push_ready;
   assign accept   = in_valid && in_ready;

   // Classify by byte count; counts above four saturate to a full word
   always_comb begin
      masked_word = '0;
      unique case (in_data.byte_count)
         3'd0: begin
            s1_kind_in = KIND_NONE;
         end
         3'd1: begin
            s1_kind_in  = KIND_TAIL;
            masked_word = {24'd0, in_data.key_word[7:0]};
         end
         3'd2: begin
            s1_kind_in  = KIND_TAIL;
            masked_word = {16'd0, in_data.key_word[15:0]};
         end
         3'd3: begin
            s1_kind_in  = KIND_TAIL;
            masked_word = {8'd0, in_data.key_word[23:0]};
         end
         default: begin
            s1_kind_in = KIND_FULL;
         end
      endcase
   end

   // First half of the k mix
   assign full_prod  = in_data.key_word * MIX_MULT;
   assign s1_data_in = (s1_kind_in == KIND_FULL) ? full_prod : masked_word;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Hold payload until the next word is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff  <= s1_data_in;
         s1_kind_ff  <= s1_kind_in;
         s1_first_ff <= in_data.first_word;
         s1_last_ff  <= in_data.last_word;
         s1_len_ff   <= in_data.key_length;
      end
   end

   // Second half of the k mix on the way into the queue
   assign k_shift = s1_data_ff ^ (s1_data_ff >> 24);
   assign k_mix   = k_shift * MIX_MULT;

   assign push_valid       = s1_valid_ff;
   assign push_data.data   = (s1_kind_ff == KIND_FULL) ? k_mix : s1_data_ff;
   assign push_data.kind   = s1_kind_ff;
   assign push_data.first  = s1_first_ff;
   assign push_data.last   = s1_last_ff;
   assign push_data.length = s1_len_ff;

endmodule

// ===== rtl/core/mkss_fifo.sv =====
module mkss_fifo
   import mkss_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  mkss_work_type push_data,
   output logic          pop_valid,
   input  logic          pop_ready,
   output mkss_work_type pop_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mkss_work_type           entry_ff [DEPTH];
   logic [IDX_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/mkss_back.sv =====
module mkss_back
   import mkss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  mkss_work_type     pop_data,
   input  logic [NODE_W-1:0] node_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mkss_rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(HASH_W);

   typedef enum logic [2:0] {
      ST_RUN,
      ST_FMUL,
      ST_FXOR,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type          state_ff;
   logic [HASH_W-1:0]  running_ff;
   logic [HASH_W-1:0]  fin_ff;
   logic [HASH_W-1:0]  div_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NODE_W-1:0]  rem_ff;
   logic [NODE_W-1:0]  nodes_ff;
   logic               rsp_valid_ff;
   logic [HASH_W-1:0]  rsp_hash_ff;
   logic [INDEX_W-1:0] rsp_index_ff;

   logic [HASH_W-1:0]  h_base;
   logic [HASH_W-1:0]  mul_op;
   logic [HASH_W-1:0]  mul_prod;
   logic [HASH_W-1:0]  h_in;
   logic [HASH_W-1:0]  fin_shift;
   logic [HASH_W-1:0]  fin_prod;
   logic [NODE_W-1:0]  nodes_in;
   logic [NODE_W:0]    trial;
   logic [NODE_W:0]    trial_sub;
   logic               out_free;

   assign pop_ready = (state_ff == ST_RUN);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Hash loop: one multiply per word
   assign h_base   = pop_data.first ? {16'd0, pop_data.length} : running_ff;
   assign mul_op   = (pop_data.kind == KIND_TAIL) ? (h_base ^ pop_data.data) : h_base;
   assign mul_prod = mul_op * MIX_MULT;

   always_comb begin
      unique case (pop_data.kind)
         KIND_FULL: h_in = mul_prod ^ pop_data.data;
         KIND_TAIL: h_in = mul_prod;
         default:   h_in = h_base;
      endcase
   end

   // Finalize multiply
   assign fin_shift = fin_ff ^ (fin_ff >> 13);
   assign fin_prod  = fin_shift * MIX_MULT;

   // Clamp node count to its legal range
   always_comb begin
      if (node_count == '0) begin
         nodes_in = NODE_MIN;
      end else if (node_count > NODE_MAX) begin
         nodes_in = NODE_MAX;
      end else begin
         nodes_in = node_count;
      end
   end

   // One restoring remainder step per cycle
   assign trial     = {rem_ff, div_ff[HASH_W-1]};
   assign trial_sub = trial - {1'b0, nodes_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop a taken result unless a new one loads this cycle
         if (rsp_ready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_RUN: begin
               if (pop_valid) begin
                  if (pop_data.last) begin
                     fin_ff     <= h_in;
                     running_ff <= '0;
                     state_ff   <= ST_FMUL;
                  end else begin
                     running_ff <= h_in;
                  end
               end
            end
            ST_FMUL: begin
               fin_ff   <= fin_prod;
               state_ff <= ST_FXOR;
            end
            ST_FXOR: begin
               fin_ff   <= fin_ff ^ (fin_ff >> 15);
               div_ff   <= fin_ff ^ (fin_ff >> 15);
               rem_ff   <= '0;
               cnt_ff   <= '0;
               nodes_ff <= nodes_in;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (trial >= {1'b0, nodes_ff}) begin
                  rem_ff <= trial_sub[NODE_W-1:0];
               end else begin
                  rem_ff <= trial[NODE_W-1:0];
               end
               div_ff <= div_ff << 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(HASH_W - 1)) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hash_ff  <= fin_ff;
                  rsp_index_ff <= rem_ff[INDEX_W-1:0];
                  state_ff     <= ST_RUN;
               end
            end
            default: begin
               state_ff <= ST_RUN;
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.hash_value   = rsp_hash_ff;
   assign rsp_data.server_index = rsp_index_ff;

endmodule

// ===== rtl/core/mkss_checker.sv =====
`include "assert_macros.svh"

module mkss_checker
   import mkss_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [HASH_W-1:0]  rsp_hash,
   input logic [INDEX_W-1:0] rsp_index
);

   // Reset drops any pending result
   `MKSS_ASSERT_RST(a_reset_clears_rsp, reset |=> !rsp_valid)

   // A stalled result stays offered
   `MKSS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)

   // A stalled result keeps its word
   `MKSS_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_hash) && $stable(rsp_index))

   // A result never follows its last word in the very next cycle
   `MKSS_ASSERT(a_no_bypass, $rose(rsp_valid) |-> !$past(req_valid && req_ready && req_last))

endmodule

bind murmur2_key_shard_select mkss_checker u_mkss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.data.last_word),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hash  (rsp_chan.data.hash_value),
   .rsp_index (rsp_chan.data.server_index)
);
